### sv/matrix_vector_multiply_defines.svh
// assertion macros used by mvm_dp
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MVM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvm check failed");

// next-cycle implication, checked out of reset
`define MVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvm check failed");

`endif

### sv/mvm_pkg.sv
`default_nettype none

package mvm_pkg;

  localparam int SUM_W      = 48;
  localparam int ROW_IDX_W  = 12;
  localparam int NUM_COLS_W = 11;
  localparam int NUM_ROWS_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;

  // input word kinds
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_MATRIX = 1'b1;

  // controller to datapath command
  typedef struct packed {
    logic load;      // write vector slot, clear the sum
    logic mac;       // multiply-accumulate one matrix element
    logic row_done;  // this element closes its row
    logic last;      // the row closed is the final one
  } mvm_cmd_t;

endpackage

`default_nettype wire

### sv/matrix_vector_multiply.sv
// dense matrix-vector multiply, y = A * x, signed fixed-point elements
// input words: start with in_action and in_value, taken when start is high
//   and busy is low; in_action low loads the next vector slot (wrapping after
//   num_cols), high is one matrix element in row-major order
// load the whole vector first, then stream the matrix rows
// results: out_strobe marks one cycle carrying out_row_sum (Q23.24),
//   out_row_index and out_last; the receiver cannot stall, a result is
//   taken at the edge ending its strobe cycle
// throughput: one word per cycle while busy is low, set by the single
//   multiply-accumulate unit and the prefetched read of the vector store
// a row's last element loads the product register at the edge that takes it;
//   the output register and out_strobe load at the next one
// config: cfg_we with cfg_index 0 (num_cols) or 1 (num_rows); write only
//   while no result is pending
// reset: synchronous on rst_n low; positions and sum clear, both sizes go
//   to 1, busy is high during reset and drops the cycle after; the vector
//   store is not cleared and must be loaded before use
`default_nettype none

module matrix_vector_multiply #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 4096,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_action,
  input  logic signed [ELEM_WIDTH-1:0]         in_value,
  // result channel
  output logic                                 out_strobe,
  output logic signed [mvm_pkg::SUM_W-1:0]     out_row_sum,
  output logic [mvm_pkg::ROW_IDX_W-1:0]        out_row_index,
  output logic                                 out_last,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  mvm_pkg::mvm_cmd_t cmd;
  logic [CAW-1:0]    wr_addr;
  logic [CAW-1:0]    rd_addr;
  logic [RAW-1:0]    row_idx;

  // position counters, size registers and word decode
  mvm_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .row_idx   (row_idx)
  );

  // vector store, multiplier and 48-bit accumulator
  mvm_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .row_idx       (row_idx),
    .out_row_sum   (out_row_sum),
    .out_row_index (out_row_index),
    .out_last      (out_last),
    .out_strobe    (out_strobe)
  );

endmodule

`default_nettype wire

### sv/mvm_ctrl.sv
`default_nettype none

module mvm_ctrl #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096,
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            in_action,
  output logic                            busy,
  input  logic                            cfg_we,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mvm_pkg::mvm_cmd_t               cmd,
  output logic [CAW-1:0]                  wr_addr,
  output logic [CAW-1:0]                  rd_addr,
  output logic [RAW-1:0]                  row_idx
);

  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  logic [mvm_pkg::NUM_COLS_W-1:0] num_cols_r;
  logic [mvm_pkg::NUM_ROWS_W-1:0] num_rows_r;
  logic [CAW-1:0] load_r, load_nxt;
  logic [CAW-1:0] col_r, col_nxt;
  logic [RAW-1:0] row_r, row_nxt;
  logic           busy_r;

  logic [CCW-1:0] cols_eff, load_inc, col_inc;
  logic [RCW-1:0] rows_eff, row_inc;
  logic [CAW-1:0] load_pos;
  logic [RAW-1:0] row_sel;
  logic           accept, row_done, is_last;

  always_comb begin
    if (num_cols_r == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(num_cols_r) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(num_cols_r);
    end
    if (num_rows_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(num_rows_r) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(num_rows_r);
    end
  end

  assign accept = start && !busy_r;

  always_comb begin
    // load slot restarts when the size shrank below it
    load_pos = (CCW'(load_r) >= cols_eff) ? '0 : load_r;
    load_inc = CCW'(load_pos) + CCW'(1);
    col_inc  = CCW'(col_r) + CCW'(1);
    row_done = (col_inc >= cols_eff);
    row_sel  = (RCW'(row_r) >= rows_eff) ? RAW'(rows_eff - RCW'(1)) : row_r;
    row_inc  = RCW'(row_sel) + RCW'(1);
    is_last  = (row_inc >= rows_eff);

    load_nxt = load_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (accept && (in_action == mvm_pkg::ACT_LOAD)) begin
      load_nxt = (load_inc >= cols_eff) ? '0 : CAW'(load_inc);
      col_nxt  = '0;
      row_nxt  = '0;
    end else if (accept) begin
      if (row_done) begin
        col_nxt = '0;
        row_nxt = is_last ? '0 : RAW'(row_inc);
      end else begin
        col_nxt = CAW'(col_inc);
      end
    end
  end

  always_comb begin
    cmd.load     = accept && (in_action == mvm_pkg::ACT_LOAD);
    cmd.mac      = accept && (in_action == mvm_pkg::ACT_MATRIX);
    cmd.row_done = row_done;
    cmd.last     = is_last;
  end

  // prefetch: read address is the column the next word will use
  assign rd_addr = col_nxt;
  assign wr_addr = load_pos;
  assign row_idx = row_sel;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= mvm_pkg::NUM_COLS_W'(1);
      num_rows_r <= mvm_pkg::NUM_ROWS_W'(1);
      load_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      busy_r     <= 1'b1;
    end else begin
      load_r <= load_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          mvm_pkg::CFG_NUM_COLS: num_cols_r <= cfg_wdata[mvm_pkg::NUM_COLS_W-1:0];
          mvm_pkg::CFG_NUM_ROWS: num_rows_r <= cfg_wdata[mvm_pkg::NUM_ROWS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### sv/mvm_dp.sv
`default_nettype none

`include "matrix_vector_multiply_defines.svh"

module mvm_dp #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 4096,
  parameter int ELEM_WIDTH = 16,
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [ELEM_WIDTH-1:0]         in_value,
  input  mvm_pkg::mvm_cmd_t                    cmd,
  input  logic [CAW-1:0]                       wr_addr,
  input  logic [CAW-1:0]                       rd_addr,
  input  logic [RAW-1:0]                       row_idx,
  output logic signed [mvm_pkg::SUM_W-1:0]     out_row_sum,
  output logic [mvm_pkg::ROW_IDX_W-1:0]        out_row_index,
  output logic                                 out_last,
  output logic                                 out_strobe
);

  localparam int PW = 2 * ELEM_WIDTH;

  logic [ELEM_WIDTH-1:0] vec_mem [MAX_COLS];
  logic [ELEM_WIDTH-1:0] rd_data_r;

  logic signed [PW-1:0]              prod;
  logic signed [63:0]                prod_wide;
  logic signed [mvm_pkg::SUM_W-1:0]  prod_r, sum_r, acc;
  logic                              s1_load_r, s1_mac_r, s1_done_r, s1_last_r;
  logic [RAW-1:0]                    s1_row_r;
  logic [31:0]                       row_wide;
  logic signed [mvm_pkg::SUM_W-1:0]  out_sum_r;
  logic [mvm_pkg::ROW_IDX_W-1:0]     out_idx_r;
  logic                              out_last_r, out_strobe_r;

  // vector store, rd_data_r always holds the entry at the current column
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vec_mem[wr_addr] <= in_value;
    end
    if (cmd.load && (wr_addr == rd_addr)) begin
      rd_data_r <= in_value;
    end else begin
      rd_data_r <= vec_mem[rd_addr];
    end
  end

  assign prod      = in_value * $signed(rd_data_r);
  assign prod_wide = 64'(prod);
  assign acc       = sum_r + prod_r;
  assign row_wide  = 32'(s1_row_r);

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_load_r <= 1'b0;
      s1_mac_r  <= 1'b0;
    end else begin
      s1_load_r <= cmd.load;
      s1_mac_r  <= cmd.mac;
    end
    prod_r    <= prod_wide[mvm_pkg::SUM_W-1:0];
    s1_done_r <= cmd.row_done;
    s1_last_r <= cmd.last;
    s1_row_r  <= row_idx;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (s1_load_r) begin
        sum_r <= '0;
      end else if (s1_mac_r && s1_done_r) begin
        sum_r        <= '0;
        out_strobe_r <= 1'b1;
      end else if (s1_mac_r) begin
        sum_r <= acc;
      end
    end
    if (s1_mac_r && s1_done_r) begin
      out_sum_r  <= acc;
      out_idx_r  <= row_wide[mvm_pkg::ROW_IDX_W-1:0];
      out_last_r <= s1_last_r;
    end
  end

  assign out_row_sum   = out_sum_r;
  assign out_row_index = out_idx_r;
  assign out_last      = out_last_r;
  assign out_strobe    = out_strobe_r;

  `MVM_ASSERT_NOW(a_one_kind, s1_load_r, !s1_mac_r)
  `MVM_ASSERT_NEXT(a_strobe_on_row_end, s1_mac_r && s1_done_r, out_strobe_r)
  `MVM_ASSERT_NEXT(a_no_stray_strobe, !(s1_mac_r && s1_done_r), !out_strobe_r)
  `MVM_ASSERT_NEXT(a_load_clears_sum, s1_load_r, sum_r == '0)

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int VEC_DEPTH = 1024;
  localparam int ROW_DEPTH = 4096;
  localparam int ELEM_W    = 16;

  // register indexes past the two real registers, written only to show they are ignored
  localparam logic [mvm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [mvm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // one expected row result
  typedef struct {
    logic [mvm_pkg::SUM_W-1:0]     sum;
    logic [mvm_pkg::ROW_IDX_W-1:0] idx;
    logic                          last;
  } row_sum_t;

  // predicts row sums from the accepted words and checks every strobed result
  class dot_product_board;
    logic signed [ELEM_W-1:0]       vec_mem [VEC_DEPTH];
    bit                             vec_valid [VEC_DEPTH];
    logic [mvm_pkg::NUM_COLS_W-1:0] cols_reg;
    logic [mvm_pkg::NUM_ROWS_W-1:0] rows_reg;
    int unsigned                    load_pos;
    int unsigned                    col_pos;
    int unsigned                    row_pos;
    logic [mvm_pkg::SUM_W-1:0]      acc;
    row_sum_t                       row_sums_due[$];
    int unsigned                    errors;

    function new();
      cols_reg = 1;
      rows_reg = 1;
      load_pos = 0;
      col_pos  = 0;
      row_pos  = 0;
      acc      = '0;
      errors   = 0;
      foreach (vec_valid[i]) vec_valid[i] = 1'b0;
    endfunction

    // zero acts as one, anything past the maximum acts as the maximum
    function int unsigned eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > VEC_DEPTH) return VEC_DEPTH;
      return cols_reg;
    endfunction

    function int unsigned eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > ROW_DEPTH) return ROW_DEPTH;
      return rows_reg;
    endfunction

    function void write_reg(logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                            logic [mvm_pkg::CFG_DATA_W-1:0] data);
      if (idx == mvm_pkg::CFG_NUM_COLS) cols_reg = data[mvm_pkg::NUM_COLS_W-1:0];
      else if (idx == mvm_pkg::CFG_NUM_ROWS) rows_reg = data[mvm_pkg::NUM_ROWS_W-1:0];
    endfunction

    // the vector slot the next matrix word reads has been loaded
    function bit column_ready();
      return vec_valid[col_pos];
    endfunction

    function void note_word(logic act, logic signed [ELEM_W-1:0] v);
      int unsigned cols;
      int unsigned rows;
      int unsigned col;
      int unsigned row;
      logic signed [2*ELEM_W-1:0] prod;
      row_sum_t r;
      bit is_last;
      cols = eff_cols();
      rows = eff_rows();
      if (act == mvm_pkg::ACT_LOAD) begin
        if (load_pos >= cols) load_pos = 0;
        vec_mem[load_pos]   = v;
        vec_valid[load_pos] = 1'b1;
        load_pos++;
        if (load_pos >= cols) load_pos = 0;
        col_pos = 0;
        row_pos = 0;
        acc     = '0;
        return;
      end
      col = col_pos;
      if (col >= VEC_DEPTH) col = 0;
      prod = v * vec_mem[col];
      acc  = acc + {{(mvm_pkg::SUM_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
      if (col + 1 < cols) begin
        col_pos = col + 1;
        return;
      end
      // row closes; a row position past a shrunken size folds onto the last row
      row = row_pos;
      if (row >= rows) row = rows - 1;
      is_last = (row + 1 >= rows);
      r.sum  = acc;
      r.idx  = row[mvm_pkg::ROW_IDX_W-1:0];
      r.last = is_last;
      row_sums_due.push_back(r);
      acc     = '0;
      col_pos = 0;
      row_pos = is_last ? 0 : row + 1;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_row_sum(logic [mvm_pkg::SUM_W-1:0] sum,
                       logic [mvm_pkg::ROW_IDX_W-1:0] idx, logic last);
      row_sum_t r;
      if (row_sums_due.size() == 0) begin
        report($sformatf("row %0d sum %0d strobed with nothing expected",
                         idx, $signed(sum)));
        return;
      end
      r = row_sums_due.pop_front();
      if (sum !== r.sum)
        report($sformatf("row %0d sum %0d, expected %0d", r.idx, $signed(sum),
                         $signed(r.sum)));
      if (idx !== r.idx)
        report($sformatf("row index %0d, expected %0d", idx, r.idx));
      if (last !== r.last)
        report($sformatf("row %0d last %0b, expected %0b", r.idx, last, r.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic signed [ELEM_W-1:0] in_value = '0;
  logic out_strobe;
  logic signed [mvm_pkg::SUM_W-1:0] out_row_sum;
  logic [mvm_pkg::ROW_IDX_W-1:0] out_row_index;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [mvm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mvm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  dot_product_board board;
  int unsigned idle_pct = 0;    // chance in a hundred that the sender idles instead of sending
  int unsigned words_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_vector_multiply i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_row_sum  (out_row_sum),
    .out_row_index(out_row_index),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // results cannot be held off, so every strobe cycle is one result
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_row_sum(out_row_sum, out_row_index, out_last);
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // element value, biased toward the extremes now and then
  function automatic logic signed [ELEM_W-1:0] rand_elem();
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return ELEM_W'($urandom);
  endfunction

  // random sender gaps; start stays high across back-to-back words
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold the word until the edge where busy is low
  task automatic send_word(input logic act, input logic signed [ELEM_W-1:0] v);
    idle_gap();
    start     <= 1'b1;
    in_action <= act;
    in_value  <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(act, v);
    words_sent++;
  endtask

  // matrix word, unless its vector slot was never loaded: then a load word instead
  task automatic send_matrix(input logic signed [ELEM_W-1:0] v);
    if (board.column_ready()) send_word(mvm_pkg::ACT_MATRIX, v);
    else send_word(mvm_pkg::ACT_LOAD, rand_elem());
  endtask

  // sender pauses until every expected row sum is in
  task automatic settle_results();
    start <= 1'b0;
    while (board.row_sums_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, with cfg_we dropped again after it
  task automatic cfg_write(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[mvm_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data[mvm_pkg::CFG_DATA_W-1:0]);
    @(posedge clk);
  endtask

  // sizes first, a fresh vector most of the time, then whole rows plus some stray words
  task automatic random_phase();
    int unsigned pick;
    int unsigned cols;
    int unsigned rows;
    int unsigned ec;
    int unsigned er;
    int unsigned count;
    int unsigned modes [4];
    modes = '{0, 73, 0, 25};
    pick = $urandom_range(99);
    cols = (pick < 5) ? 0 : (pick < 12) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    rows = ($urandom_range(99) < 5) ? 0 : $urandom_range(6, 1);
    settle_results();
    pick = $urandom_range(99);
    if (pick < 90) cfg_write(mvm_pkg::CFG_NUM_COLS, cols);
    if (pick >= 80 || pick < 70) cfg_write(mvm_pkg::CFG_NUM_ROWS, rows);
    if ($urandom_range(99) < 5) cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
    idle_pct = modes[$urandom_range(3)];
    ec = board.eff_cols();
    er = board.eff_rows();
    if ($urandom_range(99) < 85) begin
      repeat (ec) send_word(mvm_pkg::ACT_LOAD, rand_elem());
    end
    count = ec * er * $urandom_range(2, 1);
    // a ragged tail leaves a row open across the next size change
    if ($urandom_range(99) < 20) count += $urandom_range(ec, 1);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) send_word(mvm_pkg::ACT_LOAD, rand_elem());
      else begin
        if (pick < 8) settle_results();
        send_matrix(rand_elem());
      end
    end
  endtask

  initial begin
    int unsigned waited;
    board = new();

    // reset, then wait for busy to drop
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // default 1x1: extreme products, positive and negative
    send_word(mvm_pkg::ACT_LOAD, 16'sh8000);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh8000);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh7fff);

    // 2 rows of 3, extremes in both operands
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 3);
    cfg_write(mvm_pkg::CFG_NUM_ROWS, 2);
    send_word(mvm_pkg::ACT_LOAD, 16'sh7fff);
    send_word(mvm_pkg::ACT_LOAD, 16'sh8000);
    send_word(mvm_pkg::ACT_LOAD, 16'sh0001);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh8000);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh7fff);
    send_word(mvm_pkg::ACT_MATRIX, 16'shffff);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh7fff);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh7fff);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh0000);

    // row left open, then columns shrink below the column position
    send_word(mvm_pkg::ACT_MATRIX, 16'sh1234);
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 1);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh7fff);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh8000);

    // rows shrink below the row position: the next row folds onto the last
    send_word(mvm_pkg::ACT_MATRIX, 16'sh0100);
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_ROWS, 1);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh0200);

    // load position beyond the new size restarts at slot 0
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 3);
    send_word(mvm_pkg::ACT_LOAD, 16'sh4000);
    send_word(mvm_pkg::ACT_LOAD, 16'shc000);
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 2);
    send_word(mvm_pkg::ACT_LOAD, 16'sh2000);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh7fff);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh8000);

    // zero sizes act as one
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 0);
    cfg_write(mvm_pkg::CFG_NUM_ROWS, 0);
    send_word(mvm_pkg::ACT_MATRIX, 16'sh5555);

    // writes to the spare indexes change nothing
    settle_results();
    cfg_write(CFG_SPARE_A, 13'h1fff);
    cfg_write(CFG_SPARE_B, 13'h1fff);
    send_word(mvm_pkg::ACT_MATRIX, 16'shaaaa);

    // oversized sizes clamp: a long row stays open, then shrinks to close
    idle_pct = 25;
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 2047);
    cfg_write(mvm_pkg::CFG_NUM_ROWS, 8191);
    repeat (40) send_word(mvm_pkg::ACT_LOAD, rand_elem());
    repeat (39) send_matrix(rand_elem());
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 40);
    send_matrix(rand_elem());
    settle_results();
    cfg_write(mvm_pkg::CFG_NUM_COLS, 1);
    repeat (6) send_matrix(rand_elem());

    // random phases of small sizes
    while (words_sent < 700) random_phase();

    // drain, bounded
    start <= 1'b0;
    waited = 0;
    while (board.row_sums_due.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.row_sums_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
